### rtl/vgmc_pkg.sv
// Package for the vblank genlock margin control block: sizes, codes,
// reset values and the structs that pass between its modules.
// No dependencies.
package vgmc_pkg;

    localparam int HEADS      = 4;
    localparam int HIDX_W     = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam int TS_W       = 32;
    localparam int LAT_W      = 32;
    localparam int CNT_W      = 9;
    localparam int MARGIN_W   = 8;
    localparam int DRIFT_W    = 34;
    localparam int ACC_W      = 35;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] FRAME_PERIOD_RST = 16'd16666;
    localparam logic [15:0] DRIFT_WRAP_RST   = 16'd10000;
    localparam logic [15:0] LAT_THRESH_RST   = 16'd33;
    localparam logic [7:0]  REFRACTORY_RST   = 8'd20;
    localparam logic [7:0]  MARGIN_LIMIT_RST = 8'd20;
    localparam logic [7:0]  INIT_MARGIN_RST  = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_PERIOD = 3'd0,
        CFG_DRIFT_WRAP   = 3'd1,
        CFG_LAT_THRESH   = 3'd2,
        CFG_REFRACTORY   = 3'd3,
        CFG_MARGIN_LIMIT = 3'd4,
        CFG_INIT_MARGIN  = 3'd5
    } cfg_index_t;

    typedef enum logic {
        FUNC_PULSE  = 1'b0,
        FUNC_VBLANK = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_SHORTEN  = 2'd1,
        ACT_LENGTHEN = 2'd2,
        ACT_BLOCKED  = 2'd3
    } action_t;

    typedef struct packed {
        func_t             func;
        logic [1:0]        head;
        logic [TS_W-1:0]   timestamp_us;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              head_out;
        logic signed [LAT_W-1:0] latency_us;
        logic signed [LAT_W-1:0] drift_avg;
        action_t                 action;
        logic [MARGIN_W-1:0]     margin_lines;
    } out_item_t;

    typedef struct packed {
        logic [15:0] frame_period;
        logic [15:0] drift_wrap;
        logic [15:0] lat_thresh;
        logic [7:0]  refractory;
        logic [7:0]  margin_limit;
    } cfg_t;

    // One entry of the per-head state memory
    typedef struct packed {
        logic signed [LAT_W-1:0] last_lat;
        logic signed [LAT_W-1:0] avg;
        logic signed [CNT_W-1:0] count;
        logic [MARGIN_W-1:0]     margin;
    } head_state_t;

    localparam head_state_t STATE_RST = '{
        last_lat: '1,
        avg:      '0,
        count:    {1'b0, REFRACTORY_RST},
        margin:   INIT_MARGIN_RST
    };

    // Most recent write into the state memory, kept for bypass
    typedef struct packed {
        logic              vld;
        logic [HIDX_W-1:0] idx;
        head_state_t       data;
    } wb_t;

    typedef struct packed {
        logic [1:0]              head;
        logic [HIDX_W-1:0]       idx;
        logic signed [LAT_W-1:0] latency;
    } s1_t;

    typedef struct packed {
        logic [1:0]                head;
        logic [HIDX_W-1:0]         idx;
        logic signed [LAT_W-1:0]   latency;
        logic                      prev_pos;
        logic signed [DRIFT_W-1:0] drift;
        logic                      fold_hi;
        logic                      fold_lo;
        head_state_t               st;
    } s2_t;

endpackage

### rtl/vgmc_state_ram.sv
// Per-head state memory: one read port with registered data, one write port,
// valid bits standing in for the reset contents, and a last-write register.
// Depends on vgmc_pkg.
module vgmc_state_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [vgmc_pkg::HIDX_W-1:0] rd_idx,
    output vgmc_pkg::head_state_t      rd_data,
    input  logic                       wr_en,
    input  logic [vgmc_pkg::HIDX_W-1:0] wr_idx,
    input  vgmc_pkg::head_state_t      wr_data,
    output vgmc_pkg::wb_t              wb
);
    import vgmc_pkg::*;

    head_state_t       state_mem [HEADS];
    logic [HEADS-1:0]  vld_reg;
    head_state_t       rd_data_reg;
    logic              rd_vld_reg;
    logic              wb_vld_reg;
    logic [HIDX_W-1:0] wb_idx_reg;
    head_state_t       wb_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= state_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            wb_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
                wb_vld_reg      <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wb_idx_reg  <= wr_idx;
            wb_data_reg <= wr_data;
        end
    end

    // An entry never written reads as its reset contents
    assign rd_data = rd_vld_reg ? rd_data_reg : STATE_RST;

    assign wb.vld  = wb_vld_reg;
    assign wb.idx  = wb_idx_reg;
    assign wb.data = wb_data_reg;

endmodule

### rtl/vgmc_drift.sv
// First compute stage: merges memory data with pending writes, forms the
// wrapped drift and the folded latency compares. Depends on vgmc_pkg.
module vgmc_drift (
    input  vgmc_pkg::s1_t         s1,
    input  vgmc_pkg::head_state_t rd,
    input  vgmc_pkg::wb_t         wb,
    input  logic                  s2_vld,
    input  vgmc_pkg::s2_t         s2,
    input  vgmc_pkg::cfg_t        cfg,
    output vgmc_pkg::s2_t         s2_next
);
    import vgmc_pkg::*;

    head_state_t               base;
    logic signed [LAT_W-1:0]   prev;
    logic signed [DRIFT_W-1:0] lat_x;
    logic signed [DRIFT_W-1:0] prev_x;
    logic signed [DRIFT_W-1:0] per_s;
    logic signed [DRIFT_W-1:0] half_s;
    logic signed [DRIFT_W-1:0] lim_s;
    logic signed [DRIFT_W-1:0] thr_s;
    logic signed [DRIFT_W-1:0] d0;
    logic signed [DRIFT_W-1:0] dm;
    logic signed [DRIFT_W-1:0] dp;
    logic signed [DRIFT_W-1:0] drift;
    logic signed [DRIFT_W-1:0] folded;

    // The write captured in wb was missed by the read; the item in the next
    // stage has not written yet, so take its latency directly.
    assign base = (wb.vld && (wb.idx == s1.idx)) ? wb.data : rd;
    assign prev = (s2_vld && (s2.idx == s1.idx)) ? s2.latency : base.last_lat;

    assign lat_x  = DRIFT_W'(s1.latency);
    assign prev_x = DRIFT_W'(prev);
    assign per_s  = DRIFT_W'(cfg.frame_period);
    assign half_s = DRIFT_W'(cfg.frame_period >> 1);
    assign lim_s  = DRIFT_W'(cfg.drift_wrap);
    assign thr_s  = DRIFT_W'(cfg.lat_thresh);

    assign d0 = lat_x - prev_x;
    assign dm = lat_x - prev_x - per_s;
    assign dp = lat_x - prev_x + per_s;

    always_comb
    begin
        if (d0 > lim_s)
        begin
            // a period taken off and put back again leaves the raw change
            drift = (dm < -lim_s) ? d0 : dm;
        end
        else if (d0 < -lim_s)
        begin
            drift = dp;
        end
        else
        begin
            drift = d0;
        end
    end

    assign folded = (lat_x > half_s) ? (lat_x - per_s) : lat_x;

    always_comb
    begin
        s2_next          = '0;
        s2_next.head     = s1.head;
        s2_next.idx      = s1.idx;
        s2_next.latency  = s1.latency;
        s2_next.prev_pos = (prev > 0);
        s2_next.drift    = drift;
        s2_next.fold_hi  = (folded > thr_s);
        s2_next.fold_lo  = (folded < -thr_s);
        s2_next.st       = base;
    end

endmodule

### rtl/vgmc_update.sv
// Second compute stage: fading average, refractory count and margin step,
// giving the write-back entry and the result. Depends on vgmc_pkg.
module vgmc_update (
    input  vgmc_pkg::s2_t         s2,
    input  vgmc_pkg::wb_t         wb,
    input  vgmc_pkg::cfg_t        cfg,
    output vgmc_pkg::head_state_t wr_data,
    output vgmc_pkg::out_item_t   result
);
    import vgmc_pkg::*;

    localparam logic signed [ACC_W-1:0] AVG_MAX = ACC_W'(32'sh7fff_ffff);
    localparam logic signed [ACC_W-1:0] AVG_MIN = ACC_W'($signed(32'h8000_0000));

    head_state_t             cur;
    head_state_t             nxt;
    logic signed [ACC_W-1:0] avg_x;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] quot;
    logic signed [LAT_W-1:0] avg_new;
    logic signed [CNT_W-1:0] cnt_dec;
    logic signed [CNT_W-1:0] reload;
    action_t                 action;

    // Bypass the write made at the edge this item entered the stage
    always_comb
    begin
        cur = s2.st;
        if (wb.vld && (wb.idx == s2.idx))
        begin
            cur.avg    = wb.data.avg;
            cur.count  = wb.data.count;
            cur.margin = wb.data.margin;
        end
    end

    assign avg_x = ACC_W'(cur.avg);
    assign acc   = (avg_x <<< 1) + avg_x + ACC_W'(s2.drift);
    // divide by four, rounding toward zero
    assign quot  = acc[ACC_W-1] ? ((acc + ACC_W'(3)) >>> 2) : (acc >>> 2);

    always_comb
    begin
        if (quot > AVG_MAX)
        begin
            avg_new = AVG_MAX[LAT_W-1:0];
        end
        else if (quot < AVG_MIN)
        begin
            avg_new = AVG_MIN[LAT_W-1:0];
        end
        else
        begin
            avg_new = quot[LAT_W-1:0];
        end
    end

    assign cnt_dec = cur.count - CNT_W'(1);
    assign reload  = {1'b0, cfg.refractory};

    always_comb
    begin
        nxt          = cur;
        nxt.last_lat = s2.latency;
        action       = ACT_NONE;
        if (s2.prev_pos)
        begin
            nxt.avg   = avg_new;
            nxt.count = cnt_dec;
            if (cnt_dec <= 0)
            begin
                if (s2.fold_hi && (avg_new > 0))
                begin
                    nxt.count = reload;
                    if (cur.margin == '0)
                    begin
                        action = ACT_BLOCKED;
                    end
                    else
                    begin
                        nxt.margin = cur.margin - MARGIN_W'(1);
                        action     = ACT_SHORTEN;
                    end
                end
                else if (s2.fold_lo && (avg_new < 0))
                begin
                    nxt.count = reload;
                    if (cur.margin >= cfg.margin_limit)
                    begin
                        action = ACT_BLOCKED;
                    end
                    else
                    begin
                        nxt.margin = cur.margin + MARGIN_W'(1);
                        action     = ACT_LENGTHEN;
                    end
                end
                else
                begin
                    nxt.count = CNT_W'(1);
                end
            end
        end
    end

    assign wr_data = nxt;

    assign result.head_out     = s2.head;
    assign result.latency_us   = s2.latency;
    assign result.drift_avg    = nxt.avg;
    assign result.action       = action;
    assign result.margin_lines = nxt.margin;

endmodule

### rtl/vblank_genlock_margin_control.sv
// Top level of the vblank genlock margin control block; uses vgmc_pkg,
// vgmc_state_ram, vgmc_drift and vgmc_update. The block takes one event per
// clock unless out_ready holds back a full pipeline, pulse or vblank, any mix
// of heads, including the same head in consecutive cycles; a vblank request
// is registered with its read of the per-head state memory, then passes the
// drift stage and the update stage into the registered out_valid result.
// Pending writes to the same head are forwarded, so there are no interlock
// bubbles, and pulse events produce no result and occupy no stage. The state
// memory needs no clearing pass: per-head valid bits make unwritten entries
// read as their reset values. Configuration writes are taken every cycle and
// must be made only while the pipeline is empty; initial_margin seeds state
// only by its reset value, and refractory writes set the count reload.
module vblank_genlock_margin_control (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  vgmc_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output vgmc_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vgmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vgmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vgmc_pkg::*;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic [TS_W-1:0]   pulse_reg;
    logic [TS_W-1:0]   pulse_next;
    logic              s1_vld_reg;
    s1_t               s1_reg;
    logic              s2_vld_reg;
    s2_t               s2_reg;
    s2_t               s2_next;
    logic              out_vld_reg;
    out_item_t         out_reg;

    logic              accept;
    logic              vb_accept;
    logic              head_ok;
    logic [HIDX_W-1:0] in_idx;
    logic              out_take;
    logic              s2_go;
    logic              s2_free;
    logic              s1_free;
    head_state_t       rd_data;
    head_state_t       wr_data;
    wb_t               wb;
    out_item_t         result;

    // ---- configuration
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_PERIOD: cfg_next.frame_period = cfg_data;
                CFG_DRIFT_WRAP:   cfg_next.drift_wrap   = cfg_data;
                CFG_LAT_THRESH:   cfg_next.lat_thresh   = cfg_data;
                CFG_REFRACTORY:   cfg_next.refractory   = cfg_data[7:0];
                CFG_MARGIN_LIMIT: cfg_next.margin_limit = cfg_data[7:0];
                // initial margin acts only through its reset value: drop
                CFG_INIT_MARGIN:  cfg_next = cfg_reg;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // ---- pipeline handshake
    assign out_take = !out_vld_reg || out_ready;
    assign s2_go    = s2_vld_reg && out_take;
    assign s2_free  = !s2_vld_reg || out_take;
    assign s1_free  = !s1_vld_reg || s2_free;
    assign in_ready = s1_free;

    assign accept    = in_valid && in_ready;
    assign head_ok   = (int'(in_data.head) < HEADS);
    assign vb_accept = accept && (in_data.func == FUNC_VBLANK) && head_ok;
    assign in_idx    = HIDX_W'(in_data.head);

    assign pulse_next = (accept && (in_data.func == FUNC_PULSE))
                        ? in_data.timestamp_us : pulse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_period <= FRAME_PERIOD_RST;
            cfg_reg.drift_wrap   <= DRIFT_WRAP_RST;
            cfg_reg.lat_thresh   <= LAT_THRESH_RST;
            cfg_reg.refractory   <= REFRACTORY_RST;
            cfg_reg.margin_limit <= MARGIN_LIMIT_RST;
            pulse_reg            <= '0;
            s1_vld_reg           <= 1'b0;
            s2_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            pulse_reg <= pulse_next;
            if (s1_free)
            begin
                s1_vld_reg <= vb_accept;
            end
            if (s2_free)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (out_take)
            begin
                out_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_reg.head    <= in_data.head;
            s1_reg.idx     <= in_idx;
            s1_reg.latency <= $signed(in_data.timestamp_us - pulse_reg);
        end
        if (s2_free)
        begin
            s2_reg <= s2_next;
        end
        if (s2_go)
        begin
            out_reg <= result;
        end
    end

    vgmc_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (in_idx),
        .rd_data (rd_data),
        .wr_en   (s2_go),
        .wr_idx  (s2_reg.idx),
        .wr_data (wr_data),
        .wb      (wb)
    );

    vgmc_drift u_drift (
        .s1      (s1_reg),
        .rd      (rd_data),
        .wb      (wb),
        .s2_vld  (s2_vld_reg),
        .s2      (s2_reg),
        .cfg     (cfg_reg),
        .s2_next (s2_next)
    );

    vgmc_update u_update (
        .s2      (s2_reg),
        .wb      (wb),
        .cfg     (cfg_reg),
        .wr_data (wr_data),
        .result  (result)
    );

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // ---- assertions
    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s2_go |=> out_vld_reg)
        else $error("update stage result not registered at the output");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_vld_reg && !s2_vld_reg && !out_vld_reg) |-> in_ready)
        else $error("empty pipeline refuses a request");

    a_vb_enters: assert property (@(posedge clk) disable iff (!rst_n)
        vb_accept |=> s1_vld_reg)
        else $error("accepted vblank request lost before the drift stage");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !s2_free) |=> (s1_vld_reg && $stable(s1_reg)))
        else $error("drift stage item changed while blocked");

endmodule
